// ----- design/lfu_pkg.sv -----
// ---------------------------------------------------------------------------
// lfu_pkg : shared types and constants of the LFU cache table
// Transaction payloads, scan accumulator, update broadcast and FSM states.
// ---------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES_DFLT   = 16;
    localparam int USE_BITS_DFLT  = 16;
    localparam int CAP_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // widths sized for the largest legal parameter values
    localparam int IDX_W  = 8;
    localparam int HELD_W = 9;
    localparam int USE_W  = 32;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_out;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  found;
        logic [31:0]       found_data;
        logic [IDX_W-1:0]  found_age;
        logic [HELD_W-1:0] held;
        logic              free_ok;
        logic [IDX_W-1:0]  free_slot;
        logic              vic_ok;
        logic [IDX_W-1:0]  vic_slot;
        logic [USE_W-1:0]  vic_uses;
        logic [IDX_W-1:0]  vic_age;
        logic [31:0]       vic_key;
    } t_scan;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_TOUCH,
        UPD_INSERT
    } t_upd_op;

    typedef struct packed {
        t_upd_op          op;
        logic             wr_data;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] old_age;
        logic             fresh;
        logic [31:0]      key;
        logic [31:0]      value;
    } t_upd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

// ----- design/lfu_cell.sv -----
// ---------------------------------------------------------------------------
// lfu_cell : one entry of the LFU cache table
// Holds one entry, folds it into the passing scan accumulator and applies
// the broadcast update.
// ---------------------------------------------------------------------------
module lfu_cell #(
    parameter int ENTRIES  = lfu_pkg::ENTRIES_DFLT,
    parameter int USE_BITS = lfu_pkg::USE_BITS_DFLT,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_key,
    input  lfu_pkg::t_scan       i_acc,
    output lfu_pkg::t_scan       o_acc,
    input  lfu_pkg::t_upd        i_upd
);
    import lfu_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                r_valid;
    logic [31:0]         r_key;
    logic [31:0]         r_data;
    logic [USE_BITS-1:0] r_uses;
    logic [AW-1:0]       r_age;
    t_scan               r_acc;
    t_scan               n_acc;
    logic                w_mine;
    logic                w_older;

    assign o_acc = r_acc;

    always_comb begin
        n_acc = i_acc;
        if (r_valid) begin
            n_acc.held = i_acc.held + 1'b1;
            if (!i_acc.hit && r_key == i_key) begin
                n_acc.hit        = 1'b1;
                n_acc.found      = IDX_W'(CELL_IDX);
                n_acc.found_data = r_data;
                n_acc.found_age  = IDX_W'(r_age);
            end
            if (!i_acc.vic_ok || USE_W'(r_uses) < i_acc.vic_uses ||
                (USE_W'(r_uses) == i_acc.vic_uses && IDX_W'(r_age) > i_acc.vic_age)) begin
                n_acc.vic_ok   = 1'b1;
                n_acc.vic_slot = IDX_W'(CELL_IDX);
                n_acc.vic_uses = USE_W'(r_uses);
                n_acc.vic_age  = IDX_W'(r_age);
                n_acc.vic_key  = r_key;
            end
        end else if (!i_acc.free_ok) begin
            n_acc.free_ok   = 1'b1;
            n_acc.free_slot = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign w_mine  = (i_upd.slot == IDX_W'(CELL_IDX));
    assign w_older = r_valid && (i_upd.fresh || IDX_W'(r_age) < i_upd.old_age);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd.op == UPD_INSERT && w_mine) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_upd.op)
            UPD_TOUCH: begin
                if (w_mine) begin
                    if (r_uses != '1) r_uses <= r_uses + 1'b1;
                    if (i_upd.wr_data) r_data <= i_upd.value;
                    r_age <= '0;
                end else if (w_older) begin
                    r_age <= r_age + 1'b1;
                end
            end
            UPD_INSERT: begin
                if (w_mine) begin
                    r_key  <= i_upd.key;
                    r_data <= i_upd.value;
                    r_uses <= USE_BITS'(1);
                    r_age  <= '0;
                end else if (w_older) begin
                    r_age <= r_age + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/lfu_cache_table.sv -----
// ---------------------------------------------------------------------------
// lfu_cache_table : key-value cache, least-frequently-used replacement
// A row of entry cells with an LRU tie break; a scan accumulator walks the
// row one cell per cycle, then the update is broadcast to every cell.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity)
//
//  A transaction is accepted in ST_IDLE; in ST_SCAN the accumulator passes
//  through the cell chain; ST_UPDATE broadcasts the update and loads the
//  output register.
//  Reset is synchronous, active low: all entries invalid, capacity 16.
//  o_in_stall is high from acceptance until the update is issued; the update
//  waits while the output register still holds an untaken result.
//  Capacity writes are always ready.
// ---------------------------------------------------------------------------
module lfu_cache_table #(
    parameter int ENTRIES  = lfu_pkg::ENTRIES_DFLT,
    parameter int USE_BITS = lfu_pkg::USE_BITS_DFLT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lfu_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lfu_pkg::t_out             o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] i_cfg_data
);
    import lfu_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_cnt;
    t_in             r_in;
    logic [CAP_W-1:0] r_cap;
    logic            r_out_valid;
    t_out            r_out;
    t_out            n_out;
    t_upd            w_upd;
    t_scan           w_acc [0:ENTRIES];
    t_scan           w_res;
    logic [HELD_W-1:0] w_cap;
    logic            w_out_free;
    logic            w_issue;

    // capacity register: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // chain of entry cells; the accumulator enters empty at cell 0
    assign w_acc[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES  (ENTRIES),
            .USE_BITS (USE_BITS),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_in.key),
            .i_acc   (w_acc[g]),
            .o_acc   (w_acc[g+1]),
            .i_upd   (w_upd)
        );
    end

    assign w_res      = w_acc[ENTRIES];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_issue    = (r_state == ST_UPDATE) && w_out_free;
    assign w_cap      = (HELD_W'(r_cap) > HELD_W'(ENTRIES)) ? HELD_W'(ENTRIES)
                                                            : HELD_W'(r_cap);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (r_cnt == AW'(ENTRIES - 1)) n_state = ST_UPDATE;
            ST_UPDATE: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs: decide the update and the result from the finished scan
    always_comb begin
        w_upd         = '0;
        w_upd.op      = UPD_NONE;
        w_upd.key     = r_in.key;
        w_upd.value   = r_in.value;
        n_out         = '0;
        n_out.hit     = w_res.hit;
        o_in_stall    = (r_state != ST_IDLE);
        if (r_in.cmd == CMD_READ) begin
            if (w_res.hit) begin
                n_out.read_value = w_res.found_data;
                w_upd.op         = UPD_TOUCH;
                w_upd.slot       = w_res.found;
            end
        end else if (w_cap != '0) begin
            if (w_res.hit) begin
                // write to a held key: replace data, count a use
                w_upd.op      = UPD_TOUCH;
                w_upd.wr_data = 1'b1;
                w_upd.slot    = w_res.found;
            end else begin
                w_upd.op    = UPD_INSERT;
                w_upd.fresh = 1'b1;
                if (w_res.held < w_cap && w_res.free_ok) begin
                    w_upd.slot = w_res.free_slot;
                end else if (w_res.vic_ok) begin
                    // evict the coldest entry, ageing only those newer than it
                    w_upd.slot        = w_res.vic_slot;
                    w_upd.fresh       = 1'b0;
                    w_upd.old_age     = w_res.vic_age;
                    n_out.evicted     = 1'b1;
                    n_out.evicted_key = w_res.vic_key;
                end else begin
                    w_upd.slot = w_res.free_ok ? w_res.free_slot : '0;
                end
            end
        end
        // a touch ages entries newer than the touched one
        if (w_upd.op == UPD_TOUCH) begin
            w_upd.old_age = w_res.found_age;
        end
        if (!w_issue) begin
            w_upd.op = UPD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) r_cnt <= r_cnt + 1'b1;
            else                    r_cnt <= '0;
            if (w_issue)            r_out_valid <= 1'b1;
            else if (!i_out_stall)  r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) r_in  <= i_in_data;
        if (w_issue)                          r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_SCAN))
        else $error("accepted transaction did not start a scan");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_cnt == AW'(ENTRIES - 1)) |=> (r_state == ST_UPDATE))
        else $error("scan did not end after the last cell");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_UPDATE))
        else $error("result appeared outside the update cycle");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted))
        else $error("hit reported together with an eviction");
`endif

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb : self-checking bench for lfu_cache_table
// Drives reads and writes over small key pools so that hits, inserts and
// LFU/LRU evictions all occur, predicts every result in a scoreboard and
// compares field by field. Capacity is swept between phases while idle.
// ---------------------------------------------------------------------------
module tb;
    import lfu_pkg::*;

    class lfu_scoreboard;
        localparam int N = 16;
        localparam int UMAX = 65535;

        bit               held_v [N];
        logic [31:0]      held_key [N];
        logic [31:0]      held_data [N];
        int unsigned      held_uses [N];
        int unsigned      held_rank [N];
        int unsigned      cap_reg;
        t_out             pending [$];
        int               errors;

        function void clear();
            foreach (held_v[i]) held_v[i] = 0;
            cap_reg = 16;
            pending.delete();
            errors = 0;
        endfunction

        function void promote(int s, int unsigned old_rank);
            for (int j = 0; j < N; j++)
                if (j != s && held_v[j] && held_rank[j] < old_rank) held_rank[j]++;
            held_rank[s] = 0;
        endfunction

        function void touch(int s);
            if (held_uses[s] < UMAX) held_uses[s]++;
            promote(s, held_rank[s]);
        endfunction

        // work out the result of one accepted transaction and advance the table
        function void note_request(t_in req);
            t_out        r;
            int          found, freeslot, nheld, slot, vic;
            int unsigned cap, old_rank;
            r = '0;
            found = -1; freeslot = -1; nheld = 0;
            cap = (cap_reg > N) ? N : cap_reg;
            for (int i = 0; i < N; i++) begin
                if (held_v[i]) begin
                    nheld++;
                    if (found < 0 && held_key[i] == req.key) found = i;
                end else if (freeslot < 0) begin
                    freeslot = i;
                end
            end
            r.hit = (found >= 0);
            if (req.cmd == CMD_READ) begin
                if (found >= 0) begin
                    r.read_value = held_data[found];
                    touch(found);
                end
            end else if (cap != 0) begin
                if (found >= 0) begin
                    held_data[found] = req.value;
                    touch(found);
                end else begin
                    old_rank = N;
                    if (nheld < cap && freeslot >= 0) begin
                        slot = freeslot;
                    end else begin
                        vic = -1;
                        for (int i = 0; i < N; i++) begin
                            if (!held_v[i]) continue;
                            if (vic < 0 || held_uses[i] < held_uses[vic] ||
                                (held_uses[i] == held_uses[vic] &&
                                 held_rank[i] > held_rank[vic]))
                                vic = i;
                        end
                        if (vic < 0) begin
                            slot = (freeslot >= 0) ? freeslot : 0;
                        end else begin
                            slot = vic;
                            r.evicted = 1;
                            r.evicted_key = held_key[vic];
                            old_rank = held_rank[vic];
                        end
                    end
                    held_v[slot] = 1;
                    held_key[slot] = req.key;
                    held_data[slot] = req.value;
                    held_uses[slot] = 1;
                    promote(slot, old_rank);
                end
            end
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("ERROR %s: got %h want %h", what, got, want);
            errors++;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report("unexpected result", got.evicted_key, '0);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
            if (got.read_value !== want.read_value)
                report("read_value", got.read_value, want.read_value);
            if (got.evicted !== want.evicted)
                report("evicted", 32'(got.evicted), 32'(want.evicted));
            if (got.evicted_key !== want.evicted_key)
                report("evicted_key", got.evicted_key, want.evicted_key);
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         in_valid = 0;
    logic         in_stall;
    t_in          in_data = '0;
    logic         out_valid;
    logic         out_stall = 0;
    t_out         out_data;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    lfu_scoreboard sb;
    logic [31:0]   key_pool [8];
    bit            rx_quiet = 0;

    always #4 clk = ~clk;

    lfu_cache_table DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // hold one transaction until the block takes it, then predict its result;
    // with no gap, valid stays high for the next transaction
    task automatic send(t_cmd c, logic [31:0] k, logic [31:0] v);
        int n;
        in_valid <= 1;
        in_data  <= '{cmd: c, key: k, value: v};
        do @(posedge clk); while (in_stall);
        sb.note_request(in_data);
        n = gap_len();
        if (n != 0) begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // drop valid, drain, then give the block time to go quiet
    task automatic wait_idle();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_capacity(int unsigned c);
        wait_idle();
        cfg_valid <= 1;
        cfg_data  <= c[CAP_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.cap_reg = c;
    endtask

    // receiver: random stalls, checks each taken result
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            out_stall <= rx_quiet ? 1'b0 : (gap_len() != 0);
        end
    end

    task automatic random_phase(int n);
        int         p;
        logic [31:0] k;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            // well-formed traffic on a small pool, with some one-off keys
            k = (p < 85) ? key_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 15)
                         : $urandom;
            send(($urandom_range(0, 1)) ? CMD_WRITE : CMD_READ, k, $urandom);
            if (i % 97 == 50) rx_quiet = ~rx_quiet;
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, hits, update, miss
        send(CMD_READ,  32'h8000_0000, 32'h0);
        send(CMD_WRITE, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_WRITE, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_WRITE, 32'h0,         32'h0);
        send(CMD_READ,  32'h8000_0000, 32'hFFFF_FFFF);
        send(CMD_WRITE, 32'h7FFF_FFFF, 32'h1234_5678);
        send(CMD_READ,  32'h7FFF_FFFF, 32'h0);
        // sender pause until everything has come back
        wait_idle();
        // tiny capacity: evictions, LRU tie break
        set_capacity(2);
        send(CMD_WRITE, 32'd1, 32'd11);
        send(CMD_WRITE, 32'd2, 32'd22);
        send(CMD_READ,  32'd1, 32'd0);
        send(CMD_WRITE, 32'd3, 32'd33);
        send(CMD_WRITE, 32'd4, 32'd44);
        // capacity zero ignores writes, reads still work
        set_capacity(0);
        send(CMD_WRITE, 32'd9, 32'd99);
        send(CMD_READ,  32'd9, 32'd0);
        send(CMD_READ,  32'd1, 32'd0);
        // above the table size is treated as full size
        set_capacity(31);
        for (int i = 0; i < 18; i++) send(CMD_WRITE, 32'h100 + i, i);

        set_capacity(1);  random_phase(200);
        set_capacity(16); random_phase(400);
        set_capacity(5);  random_phase(300);
        set_capacity(0);  random_phase(60);
        set_capacity(3);  random_phase(300);
        set_capacity(31); random_phase(400);

        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0) $display("lfu_cache_table: match");
        else $display("lfu_cache_table: mismatch");
        $finish;
    end

    initial begin
        #8000000;
        $display("lfu_cache_table: mismatch");
        $finish;
    end
endmodule
